// ===== rtl/core/brfifo_pkg.sv =====
// Shared types and constants for the byte ring FIFO with peek and discard.
// Used by the controller, the datapath and the top level; no dependencies.
package brfifo_pkg;

  // Field widths of requests and results.
  localparam int KIND_W   = 3;
  localparam int DATA_W   = 8;
  localparam int OFFS_W   = 10;
  localparam int CNT_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Default store depth and the size register's reset value.
  localparam int DEPTH_DEFAULT = 1024;
  localparam int SIZE_RESET    = 1024;

  // Register index of the ring size register.
  localparam logic REG_IDX_SIZE = 1'b0;

  // Operation codes carried in the kind field.
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_PUSH    = 3'd0;
  localparam kind_t KIND_POP     = 3'd1;
  localparam kind_t KIND_PEEK    = 3'd2;
  localparam kind_t KIND_DISCARD = 3'd3;
  localparam kind_t KIND_FLUSH   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming request
    logic exec;     // perform the operation and the store access
    logic load;     // load the result into the output register
  } brfifo_cmd_t;

endpackage

// ===== rtl/core/brfifo_ctrl.sv =====
// Controller for the byte ring FIFO: sequences capture, execute and result load.
// Depends on brfifo_pkg for the command struct.
module brfifo_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    m_tready,
  output logic                    m_tvalid,
  output brfifo_pkg::brfifo_cmd_t cmd
);
  import brfifo_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_valid;
  logic   load_ok;

  // The result may be loaded once the output register is free or being drained.
  assign load_ok = (state == S_LOAD) && (!out_valid || m_tready);

  // Command decode from the current state.
  always_comb begin
    s_tready    = (state == S_IDLE);
    cmd.capture = (state == S_IDLE) && s_tvalid;
    cmd.exec    = (state == S_EXEC);
    cmd.load    = load_ok;
  end

  assign m_tvalid = out_valid;

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_ok) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/brfifo_dp.sv =====
// Datapath for the byte ring FIFO: byte store, ring indices, size register
// and result register. Depends on brfifo_pkg; driven by brfifo_ctrl commands.
module brfifo_dp #(
  parameter int DEPTH = brfifo_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  brfifo_pkg::brfifo_cmd_t           cmd,
  input  brfifo_pkg::kind_t                 kind_in,
  input  logic [brfifo_pkg::DATA_W-1:0]     data_in,
  input  logic [brfifo_pkg::OFFS_W-1:0]     offset_in,
  input  logic                              cfg_we,
  input  logic [brfifo_pkg::SIZE_W-1:0]     cfg_size,
  output logic [$clog2(DEPTH+1)-1:0]        size_value,
  output logic                              ok,
  output logic [brfifo_pkg::DATA_W-1:0]     data_out,
  output logic [brfifo_pkg::CNT_W-1:0]      fill_count,
  output logic [brfifo_pkg::CNT_W-1:0]      free_space
);
  import brfifo_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int SZW = $clog2(DEPTH + 1);
  // Working width for counts and compares: holds DEPTH and the 11-bit register.
  localparam int CW  = (SZW > SIZE_W) ? SZW : SIZE_W;
  localparam int SIZE_INIT = (DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]     wr_idx;
  logic [AW-1:0]     rd_idx;
  logic [SZW-1:0]    size_reg;
  kind_t             kind_q;
  logic [DATA_W-1:0] data_q;
  logic [OFFS_W-1:0] offs_q;
  logic              ok_q;
  logic              rd_sel_q;
  logic [DATA_W-1:0] mem_rdata;

  logic [CW-1:0]     size_w;
  logic [CW-1:0]     wr_w;
  logic [CW-1:0]     rd_w;
  logic [CW-1:0]     offs_w;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     wr_next;
  logic [CW-1:0]     add_b;
  logic [CW:0]       sum;
  logic [CW:0]       sum_wrapped;
  logic [CW-1:0]     rd_adv;
  logic [CW-1:0]     cfg_ext;
  logic [CW-1:0]     cfg_sat;
  logic              op_ok;
  logic              op_reads;
  logic              push_go;

  assign size_w = CW'(size_reg);
  assign wr_w   = CW'(wr_idx);
  assign rd_w   = CW'(rd_idx);
  assign offs_w = CW'(offs_q);

  // Bytes held, from the current ring indices.
  always_comb begin
    if (wr_w >= rd_w) begin
      fill = wr_w - rd_w;
    end else begin
      fill = size_w - rd_w + wr_w;
    end
  end

  // Next write position, wrapping at the ring size.
  assign wr_next = ((wr_w + CW'(1)) == size_w) ? '0 : (wr_w + CW'(1));

  // Read-side advance: one for pop, the offset for peek and discard.
  assign add_b       = (kind_q == KIND_POP) ? CW'(1) : offs_w;
  assign sum         = {1'b0, rd_w} + {1'b0, add_b};
  assign sum_wrapped = (sum >= {1'b0, size_w}) ? (sum - {1'b0, size_w}) : sum;
  assign rd_adv      = sum_wrapped[CW-1:0];

  // Success and read decision for the captured request.
  always_comb begin
    op_ok    = 1'b0;
    op_reads = 1'b0;
    case (kind_q)
      KIND_PUSH:    op_ok = (wr_next != rd_w);
      KIND_POP: begin
        op_ok    = (fill != '0);
        op_reads = 1'b1;
      end
      KIND_PEEK: begin
        op_ok    = (offs_w < fill);
        op_reads = 1'b1;
      end
      KIND_DISCARD: op_ok = (offs_w <= fill);
      KIND_FLUSH:   op_ok = 1'b1;
      default:      op_ok = 1'b0;
    endcase
  end

  assign push_go = cmd.exec && (kind_q == KIND_PUSH) && op_ok;

  // Size register write value, saturated into 2..DEPTH.
  assign cfg_ext = CW'(cfg_size);
  always_comb begin
    if (cfg_ext < CW'(2)) begin
      cfg_sat = CW'(2);
    end else if (cfg_ext > CW'(DEPTH)) begin
      cfg_sat = CW'(DEPTH);
    end else begin
      cfg_sat = cfg_ext;
    end
  end

  // Captured request fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind_in;
      data_q <= data_in;
      offs_q <= offset_in;
    end
  end

  // Byte store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (push_go) begin
      mem[wr_idx] <= data_q;
    end
    if (cmd.exec && op_reads) begin
      mem_rdata <= mem[rd_adv[AW-1:0] & {AW{kind_q != KIND_POP}} |
                       (rd_idx & {AW{kind_q == KIND_POP}})];
    end
  end

  // Ring indices and size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx   <= '0;
      rd_idx   <= '0;
      size_reg <= SZW'(SIZE_INIT);
    end else if (cfg_we) begin
      size_reg <= cfg_sat[SZW-1:0];
      wr_idx   <= '0;
      rd_idx   <= '0;
    end else if (cmd.exec && op_ok) begin
      case (kind_q)
        KIND_PUSH:    wr_idx <= wr_next[AW-1:0];
        KIND_POP:     rd_idx <= rd_adv[AW-1:0];
        KIND_DISCARD: rd_idx <= rd_adv[AW-1:0];
        KIND_FLUSH:   rd_idx <= wr_idx;
        default:      rd_idx <= rd_idx;
      endcase
    end
  end

  // Outcome flags kept from the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_q     <= op_ok;
      rd_sel_q <= op_ok && op_reads;
    end
  end

  // Result register; counts come from the updated indices.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok         <= ok_q;
      data_out   <= rd_sel_q ? mem_rdata : '0;
      fill_count <= fill[CNT_W-1:0];
      free_space <= CNT_W'(size_w - CW'(1) - fill);
    end
  end

  assign size_value = size_reg;

endmodule

// ===== rtl/core/byte_ring_fifo_with_peek_discard.sv =====
// A request is taken in the controller's capture step, executed in its store access
// step and its result is then loaded into the output register; the result load waits
// while the output register holds a result not yet taken. No new request is taken
// until the result of the last one has been loaded into the output register.
// Reset (rst, synchronous, active high) empties the ring and sets the size
// register to 1024 (or DEPTH if smaller); the byte store is not cleared.
module byte_ring_fifo_with_peek_discard #(
  parameter int DEPTH = brfifo_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // data_in[7:0], offset[17:8], zero
  input  logic [brfifo_pkg::KIND_W-1:0]  s_tuser,  // kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,  // data_out, fill_count, free_space, zero
  output logic                           m_tuser,  // ok
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brfifo_pkg::APB_AW-1:0]  paddr,
  input  logic [brfifo_pkg::APB_DW-1:0]  pwdata,
  output logic [brfifo_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);
  import brfifo_pkg::*;

  localparam int SZW = $clog2(DEPTH + 1);

  brfifo_cmd_t        cmd;
  logic               cfg_we;
  logic [SZW-1:0]     size_value;
  logic               res_ok;
  logic [DATA_W-1:0]  res_data;
  logic [CNT_W-1:0]   res_fill;
  logic [CNT_W-1:0]   res_free;

  // Register port: always ready, one register at index zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_SIZE);
  assign prdata = (paddr[2] == REG_IDX_SIZE) ? APB_DW'(size_value) : '0;

  brfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  brfifo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind_in    (s_tuser),
    .data_in    (s_tdata[7:0]),
    .offset_in  (s_tdata[17:8]),
    .cfg_we     (cfg_we),
    .cfg_size   (pwdata[SIZE_W-1:0]),
    .size_value (size_value),
    .ok         (res_ok),
    .data_out   (res_data),
    .fill_count (res_fill),
    .free_space (res_free)
  );

  // Result packing, lowest field first.
  assign m_tuser = res_ok;
  assign m_tdata = {4'b0000, res_free, res_fill, res_data};

endmodule

// ===== tb/byte_ring_fifo_with_peek_discard_test.sv =====
// Self-checking testbench for the byte ring FIFO with peek and discard.
// Needs brfifo_pkg and byte_ring_fifo_with_peek_discard; drives requests on the
// stream port, resizes the ring over APB and checks every result against a model or a table entry.
module byte_ring_fifo_with_peek_discard_test;
  import brfifo_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [APB_AW-1:0] SIZE_ADDR = APB_AW'(4 * REG_IDX_SIZE);

  // Kind codes that the block does not define.
  localparam kind_t KIND_RSVD5 = 3'd5;
  localparam kind_t KIND_RSVD7 = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [7:0]  data_out;
    logic [9:0]  fill_count;
    logic [9:0]  free_space;
  } fifo_result_t;

  typedef struct packed {
    logic [10:0]  resize;  // nonzero: write the size register before this request
    kind_t        kind;
    logic [7:0]   din;
    logic [9:0]   offs;
    logic         typed;   // use the result below instead of the predictor
    fifo_result_t want;
  } req_row_t;

  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  // Directed requests: empty ring, field extremes, unused kinds, then a two-byte ring.
  localparam req_row_t DIRECTED_ROWS [26] = '{
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b1, '{1'b0, 8'h00, 10'd0, 10'd1023}},
    '{11'd0, KIND_PEEK,    8'h00, 10'd0,    1'b1, '{1'b0, 8'h00, 10'd0, 10'd1023}},
    '{11'd0, KIND_DISCARD, 8'h00, 10'd0,    1'b1, '{1'b1, 8'h00, 10'd0, 10'd1023}},
    '{11'd0, KIND_DISCARD, 8'h00, 10'd1023, 1'b1, '{1'b0, 8'h00, 10'd0, 10'd1023}},
    '{11'd0, KIND_PUSH,    8'hFF, 10'd0,    1'b1, '{1'b1, 8'h00, 10'd1, 10'd1022}},
    '{11'd0, KIND_PUSH,    8'h00, 10'd1023, 1'b1, '{1'b1, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_PEEK,    8'h00, 10'd0,    1'b1, '{1'b1, 8'hFF, 10'd2, 10'd1021}},
    '{11'd0, KIND_PEEK,    8'hFF, 10'd1,    1'b1, '{1'b1, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_PEEK,    8'h00, 10'd2,    1'b1, '{1'b0, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_PEEK,    8'h00, 10'd1023, 1'b1, '{1'b0, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_RSVD5,   8'hFF, 10'd1023, 1'b1, '{1'b0, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_RSVD7,   8'hFF, 10'd1023, 1'b1, '{1'b0, 8'h00, 10'd2, 10'd1021}},
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b1, '{1'b1, 8'hFF, 10'd1, 10'd1022}},
    '{11'd0, KIND_PUSH,    8'hA5, 10'd0,    1'b0, '0},
    '{11'd0, KIND_PUSH,    8'h5A, 10'd0,    1'b0, '0},
    '{11'd0, KIND_DISCARD, 8'h00, 10'd2,    1'b0, '0},
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b0, '0},
    '{11'd0, KIND_PUSH,    8'h3C, 10'd0,    1'b0, '0},
    '{11'd0, KIND_FLUSH,   8'h00, 10'd0,    1'b1, '{1'b1, 8'h00, 10'd0, 10'd1023}},
    '{11'd2, KIND_PUSH,    8'h11, 10'd0,    1'b1, '{1'b1, 8'h00, 10'd1, 10'd0}},
    '{11'd0, KIND_PUSH,    8'h22, 10'd0,    1'b1, '{1'b0, 8'h00, 10'd1, 10'd0}},
    '{11'd0, KIND_PEEK,    8'h00, 10'd0,    1'b1, '{1'b1, 8'h11, 10'd1, 10'd0}},
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b1, '{1'b1, 8'h11, 10'd0, 10'd1}},
    '{11'd0, KIND_PUSH,    8'h33, 10'd0,    1'b1, '{1'b1, 8'h00, 10'd1, 10'd0}},
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b1, '{1'b1, 8'h33, 10'd0, 10'd1}},
    '{11'd0, KIND_POP,     8'h00, 10'd0,    1'b1, '{1'b0, 8'h00, 10'd0, 10'd1}}
  };

  // Random phases: size register range, pacing, share of pushes and request count.
  localparam int NUM_PHASES = 9;
  localparam logic [31:0] PHASE_SIZE_LO [NUM_PHASES] =
    '{32'd3, 32'd0, 32'd1024, 32'd17, 32'h803, 32'd2047, 32'd1, 32'd2, 32'd4};
  localparam logic [31:0] PHASE_SIZE_HI [NUM_PHASES] =
    '{32'd3, 32'd0, 32'd1024, 32'd17, 32'h803, 32'd2047, 32'd1, 32'd64, 32'd1024};
  localparam pace_t PHASE_PACE [NUM_PHASES] = '{PACE_NONE, PACE_SENDER, PACE_RECEIVER,
    PACE_BOTH, PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH, PACE_NONE};
  localparam int PHASE_PUSH_PCT [NUM_PHASES] = '{40, 40, 75, 40, 40, 45, 40, 40, 50};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{100, 100, 180, 130, 100, 100, 80, 100, 100};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;  // data_in, offset, zero
  logic [KIND_W-1:0] s_tuser = '0;  // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;  // data_out, fill_count, free_space, zero
  logic m_tuser;  // ok
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  byte_ring_fifo_with_peek_discard dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model of the ring: its bytes, both indices and the size in use.
  logic [7:0] ring_bytes [RING_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned ring_len = SIZE_RESET;

  fifo_result_t pending_results [$];
  fifo_result_t got_result;
  fifo_result_t head_result;
  int error_count = 0;
  int idle_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned held_bytes();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_len - rd_ptr + wr_ptr;
  endfunction

  // A size write saturates into 2..depth and empties the ring.
  function automatic void resize_ring(logic [31:0] value);
    int unsigned v;
    v = value[SIZE_W-1:0];
    if (v < 2) v = 2;
    if (v > RING_DEPTH) v = RING_DEPTH;
    ring_len = v;
    wr_ptr = 0;
    rd_ptr = 0;
  endfunction

  // Applies one request to the model ring and returns the result it gives.
  function automatic fifo_result_t apply_fifo_op(kind_t kind, logic [7:0] din,
                                                 logic [9:0] offs);
    fifo_result_t r;
    int unsigned nxt;
    r = '0;
    if (wr_ptr >= ring_len) wr_ptr = 0;
    if (rd_ptr >= ring_len) rd_ptr = 0;
    case (kind)
      KIND_PUSH: begin
        nxt = (wr_ptr + 1) % ring_len;
        if (nxt != rd_ptr) begin
          ring_bytes[wr_ptr] = din;
          wr_ptr = nxt;
          r.ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (held_bytes() != 0) begin
          r.data_out = ring_bytes[rd_ptr];
          rd_ptr = (rd_ptr + 1) % ring_len;
          r.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (offs < held_bytes()) begin
          r.data_out = ring_bytes[(rd_ptr + offs) % ring_len];
          r.ok = 1'b1;
        end
      end
      KIND_DISCARD: begin
        if (offs <= held_bytes()) begin
          rd_ptr = (rd_ptr + offs) % ring_len;
          r.ok = 1'b1;
        end
      end
      KIND_FLUSH: begin
        rd_ptr = wr_ptr;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.fill_count = 10'(held_bytes());
    r.free_space = 10'(ring_len - 1 - held_bytes());
    return r;
  endfunction

  function automatic void set_pace(pace_t pace);
    idle_pct = (pace == PACE_SENDER) ? 78 : (pace == PACE_BOTH) ? 7 : 0;
    stall_pct = (pace == PACE_RECEIVER) ? 78 : (pace == PACE_BOTH) ? 7 : 0;
  endfunction

  // Presents one request, waits for it to be taken and records its result.
  task automatic issue_op(kind_t kind, logic [7:0] din, logic [9:0] offs,
                          logic typed, fifo_result_t typed_res);
    fifo_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, offs, din};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    predicted = apply_fifo_op(kind, din, offs);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(logic [31:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= SIZE_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    resize_ring(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One random request, mostly with offsets near the current fill.
  task automatic random_op(int push_pct);
    kind_t kind;
    int pick;
    int unsigned reach;
    logic [9:0] offs;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      kind = KIND_PUSH;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = KIND_POP;
      else if (pick < 65) kind = KIND_PEEK;
      else if (pick < 85) kind = KIND_DISCARD;
      else if (pick < 93) kind = KIND_FLUSH;
      else kind = kind_t'($urandom_range(KIND_RSVD5, KIND_RSVD7));
    end
    reach = held_bytes() + 1;
    if (reach > 1023) reach = 1023;
    if ($urandom_range(0, 3) != 0) offs = 10'($urandom_range(0, reach));
    else offs = 10'($urandom_range(0, 1023));
    issue_op(kind, 8'($urandom_range(0, 255)), offs, 1'b0, '0);
  endtask

  // Result side: random backpressure, changed on the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Each result taken is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result = '{m_tuser, m_tdata[7:0], m_tdata[17:8], m_tdata[27:18]};
      if (pending_results.size() == 0) begin
        $error("result taken with no request outstanding");
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("ok", head_result.ok, got_result.ok);
        check_field("data_out", head_result.data_out, got_result.data_out);
        check_field("fill_count", head_result.fill_count, got_result.fill_count);
        check_field("free_space", head_result.free_space, got_result.free_space);
      end
    end
  end

  // Watchdog on cycles where no handshake of any kind completes.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_ring_fifo_with_peek_discard regression: fail");
      $finish;
    end
  end

  initial begin
    req_row_t row;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed requests with no idling.
    set_pace(PACE_NONE);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.resize != 0) write_size(32'(row.resize));
      issue_op(row.kind, row.din, row.offs, row.typed, row.want);
    end

    // Random phases, each at its own ring size and pacing.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_pace(PACE_NONE);
      write_size($urandom_range(PHASE_SIZE_LO[p], PHASE_SIZE_HI[p]));
      set_pace(PHASE_PACE[p]);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (n == PHASE_ITEMS[p] / 2) drain_results();
        random_op(PHASE_PUSH_PCT[p]);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_ring_fifo_with_peek_discard regression: pass");
    end else begin
      $display("byte_ring_fifo_with_peek_discard regression: fail");
    end
    $finish;
  end

endmodule
